// ===== rtl/core/ssfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared types and constants for the sorted store with leftmost search.
// ----------------------------------------------------------------------------
package ssfm_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic
    {
        MODE_LOAD   = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t                     mode;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

    // Handoff from one cell to the next in the chain
    typedef struct packed
    {
        logic                      keep;
        logic signed [VALUE_W-1:0] entry;
    } link_t;

endpackage

// ===== rtl/core/ssfm_cell.sv =====
// ----------------------------------------------------------------------------
// ssfm_cell
// One slot of the sorted chain: holds an entry, shifts or takes the new value
// on a load, and flags an equal entry on a search.
// ----------------------------------------------------------------------------
module ssfm_cell
(
    input  logic                               clk,
    input  logic                               load,
    input  logic                               occupied,
    input  logic signed [ssfm_pkg::VALUE_W-1:0] value,
    input  ssfm_pkg::link_t                     prev,
    output ssfm_pkg::link_t                     next,
    output logic                               match
);

    logic signed [ssfm_pkg::VALUE_W-1:0] entry_reg;
    logic signed [ssfm_pkg::VALUE_W-1:0] entry_next;
    logic                                keep;

    assign keep       = occupied && (entry_reg <= value);
    assign match      = occupied && (entry_reg == value);
    assign next.keep  = keep;
    assign next.entry = entry_reg;

    always_comb
    begin
        priority if (keep)
        begin
            entry_next = entry_reg;
        end
        else if (prev.keep)
        begin
            entry_next = value;
        end
        else
        begin
            entry_next = prev.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== rtl/core/ssfm_first_enc.sv =====
// ----------------------------------------------------------------------------
// ssfm_first_enc
// Priority encoder: lowest matching slot of the chain.
// ----------------------------------------------------------------------------
module ssfm_first_enc
(
    input  logic [ssfm_pkg::MAX_ENTRIES-1:0] match,
    output ssfm_pkg::result_t                result
);

    logic [ssfm_pkg::IDX_W-1:0] idx;

    always_comb
    begin
        idx = '0;
        for (int i = ssfm_pkg::MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                idx = ssfm_pkg::IDX_W'(i);
            end
        end
        result.found    = |match;
        result.position = (|match) ? ssfm_pkg::POS_W'(idx) : '0;
    end

endmodule

// ===== rtl/core/sorted_store_first_match_search.sv =====
// ----------------------------------------------------------------------------
// sorted_store_first_match_search
// Sorted store of signed values in a chain of cells, with leftmost search.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at each rising edge with start high and busy low.
//   busy stays low, so one transaction per cycle is accepted.
//   item.mode = load: item.value is inserted at its sorted place;
//     every cell shifts or takes the value at once. No result.
//     A load into a full store starts a new set with that value alone.
//   item.mode = search: the result appears on result with strobe high for
//     one cycle, the cycle after acceptance. All cells compare
//     in parallel and a priority encoder picks the lowest equal slot.
//   result.found is 1 if the value is among the loaded entries;
//   result.position is the lowest such slot, 0 when not found.
//   The receiver cannot stall; each result is taken in its strobe cycle.
//   Reset empties the store (count zero) and drops any pending strobe.
// ----------------------------------------------------------------------------
module sorted_store_first_match_search
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssfm_pkg::item_t   item,
    output logic              strobe,
    output ssfm_pkg::result_t result
);

    logic [ssfm_pkg::CNT_W-1:0]       count_reg;
    logic [ssfm_pkg::CNT_W-1:0]       count_next;
    logic [ssfm_pkg::CNT_W-1:0]       live_count;
    logic                             full;
    logic                             load;
    logic                             search;
    logic                             strobe_reg;
    logic                             strobe_next;
    ssfm_pkg::result_t                result_reg;
    ssfm_pkg::result_t                result_next;
    logic [ssfm_pkg::MAX_ENTRIES-1:0] occupied;
    logic [ssfm_pkg::MAX_ENTRIES-1:0] match;
    ssfm_pkg::link_t                  links [ssfm_pkg::MAX_ENTRIES+1];

    assign busy   = 1'b0;
    assign full   = (count_reg == ssfm_pkg::CNT_W'(ssfm_pkg::MAX_ENTRIES));
    assign load   = start && !busy && (item.mode == ssfm_pkg::MODE_LOAD);
    assign search = start && !busy && (item.mode == ssfm_pkg::MODE_SEARCH);

    // drop the old set when loading into a full store
    assign live_count = (load && full) ? '0 : count_reg;

    assign links[0].keep  = 1'b1;
    assign links[0].entry = '0;

    for (genvar g = 0; g < ssfm_pkg::MAX_ENTRIES; g++)
    begin : g_cell
        assign occupied[g] = (ssfm_pkg::CNT_W'(g) < live_count);

        ssfm_cell u_cell
        (
            .clk      (clk),
            .load     (load),
            .occupied (occupied[g]),
            .value    (item.value),
            .prev     (links[g]),
            .next     (links[g+1]),
            .match    (match[g])
        );
    end

    ssfm_first_enc u_enc
    (
        .match  (match),
        .result (result_next)
    );

    always_comb
    begin
        count_next  = count_reg;
        strobe_next = search;
        if (load)
        begin
            count_next = live_count + ssfm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (search)
        begin
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ssfm_pkg::CNT_W'(ssfm_pkg::MAX_ENTRIES))
        else $error("entry count exceeds store depth");

    a_strobe_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && item.mode == ssfm_pkg::MODE_SEARCH))
        else $error("result strobe without a search transaction");

    a_pos_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.found) |-> (result.position == '0))
        else $error("nonzero position on a miss");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (count_reg != '0))
        else $error("store empty after a load");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_store_first_match_search. A driver sends
// load and search transactions from a queue, with random gaps. A shadow copy
// of the sorted store predicts every search answer. A monitor compares each
// strobed result against the oldest predicted answer.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct
    {
        ssfm_pkg::item_t payload;
        int              gap;
        bit              drain;
    } stim_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    ssfm_pkg::item_t   item  = '0;
    logic              busy;
    logic              strobe;
    ssfm_pkg::result_t result;

    stim_t             pending_items[$];
    ssfm_pkg::result_t lookup_answers[$];

    logic signed [ssfm_pkg::VALUE_W-1:0] shadow_vals [ssfm_pkg::MAX_ENTRIES];
    int      shadow_count = 0;

    stim_t   cur;
    bit      have_cur     = 1'b0;
    bit      took_item    = 1'b0;
    int      items_queued = 0;
    int      items_taken  = 0;
    int      error_count  = 0;
    int      cycle_count  = 0;

    sorted_store_first_match_search DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always #4 clk = ~clk;

    task automatic apply_to_shadow(input ssfm_pkg::item_t it);
        logic signed [ssfm_pkg::VALUE_W-1:0] key;
        int                slot;
        int                below;
        int                i;
        ssfm_pkg::result_t answer;
        key = it.value;
        if (it.mode == ssfm_pkg::MODE_LOAD)
        begin
            if (shadow_count == ssfm_pkg::MAX_ENTRIES)
                shadow_count = 0;
            slot = 0;
            while (slot < shadow_count && shadow_vals[slot] <= key)
                slot++;
            for (i = shadow_count; i > slot; i--)
                shadow_vals[i] = shadow_vals[i-1];
            shadow_vals[slot] = key;
            shadow_count++;
        end
        else
        begin
            below = 0;
            for (i = 0; i < shadow_count; i++)
                if (shadow_vals[i] < key)
                    below++;
            answer.found    = (below < shadow_count) && (shadow_vals[below] == key);
            answer.position = answer.found ? ssfm_pkg::POS_W'(below) : '0;
            lookup_answers.push_back(answer);
        end
    endtask

    task automatic push_item(input ssfm_pkg::mode_t m,
                             input logic signed [ssfm_pkg::VALUE_W-1:0] v,
                             input int gap, input bit drain);
        stim_t s;
        s.payload.mode  = m;
        s.payload.value = v;
        s.gap           = gap;
        s.drain         = drain;
        pending_items.push_back(s);
        items_queued++;
    endtask

    function automatic logic signed [ssfm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1:    pick_value = $signed($urandom_range(0, 16)) - 8;
            2:       pick_value = $urandom;
            default: pick_value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin : drive
        logic            next_start;
        ssfm_pkg::item_t next_item;
        next_start = start;
        next_item  = item;
        if (rst_n)
        begin
            if (start && took_item)
                next_start = 1'b0;
            if (!next_start)
            begin
                if (!have_cur && pending_items.size() > 0)
                begin
                    cur      = pending_items.pop_front();
                    have_cur = 1'b1;
                end
                if (have_cur)
                begin
                    if (cur.gap > 0)
                        cur.gap--;
                    else if (!cur.drain || lookup_answers.size() == 0)
                    begin
                        next_start = 1'b1;
                        next_item  = cur.payload;
                        have_cur   = 1'b0;
                    end
                end
            end
        end
        start <= next_start;
        item  <= next_item;
    end

    // monitor
    always @(posedge clk)
    begin : observe
        ssfm_pkg::result_t want;
        took_item = 1'b0;
        if (rst_n)
        begin
            if (strobe === 1'b1)
            begin
                if (lookup_answers.size() == 0)
                begin
                    $error("unexpected result: found=%0b position=%0d",
                           result.found, result.position);
                    error_count++;
                end
                else
                begin
                    want = lookup_answers.pop_front();
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, result.found);
                        error_count++;
                    end
                    if (result.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, result.position);
                        error_count++;
                    end
                end
            end
            if (start && busy === 1'b0)
            begin
                took_item = 1'b1;
                items_taken++;
                apply_to_shadow(item);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic signed [ssfm_pkg::VALUE_W-1:0] set_vals[$];
        logic signed [ssfm_pkg::VALUE_W-1:0] v;
        int  n;
        int  search_pct;
        bit  burst;
        bit  is_search;

        // directed: empty store, extremes, equal runs, full store
        push_item(ssfm_pkg::MODE_SEARCH, 0, 0, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 32'sh80000000, 0, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 32'sh7FFFFFFF, 1, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 5, 0, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 5, 2, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, -1, 0, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 5, 0, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 0, 3, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 32'sh80000000, 0, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 32'sh7FFFFFFF, 0, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 5, 1, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 4, 0, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, -1, 0, 1'b0);
        for (n = 0; n < 8; n++)
            push_item(ssfm_pkg::MODE_LOAD, 100 + n, $urandom_range(0, 2), 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 32'sh7FFFFFFF, 0, 1'b0);
        push_item(ssfm_pkg::MODE_LOAD, 3, 0, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 5, 0, 1'b0);
        push_item(ssfm_pkg::MODE_SEARCH, 3, 0, 1'b1);

        set_vals.push_back(3);
        search_pct = 40;
        burst      = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       search_pct = 10;
                    1:       search_pct = 40;
                    default: search_pct = 80;
                endcase
                burst = ($urandom_range(0, 2) == 0);
            end
            is_search = ($urandom_range(0, 99) < search_pct);
            if (is_search)
            begin
                if (set_vals.size() > 0 && $urandom_range(0, 99) < 60)
                    v = set_vals[$urandom_range(0, set_vals.size() - 1)]
                        + ($urandom_range(0, 4) == 0 ? 1 : 0);
                else
                    v = pick_value();
            end
            else
            begin
                v = pick_value();
                if (set_vals.size() == ssfm_pkg::MAX_ENTRIES)
                    set_vals.delete();
                set_vals.push_back(v);
            end
            push_item(is_search ? ssfm_pkg::MODE_SEARCH : ssfm_pkg::MODE_LOAD, v,
                      burst ? 0 : $urandom_range(0, 11), (n % 250 == 249));
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < items_queued || lookup_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ssfm_pkg.sv
rtl/core/ssfm_cell.sv
rtl/core/ssfm_first_enc.sv
rtl/core/sorted_store_first_match_search.sv
sim/testbench.sv
